### hw/rtl/byte_stream_frame_assembler_top_macros.svh
// ----------------------------------------------------------------------------
// byte stream frame assembler assertion macros
// shared concurrent assertion forms, clocked on clock and disabled in reset
// ----------------------------------------------------------------------------
`ifndef BYTE_STREAM_FRAME_ASSEMBLER_TOP_MACROS_SVH
`define BYTE_STREAM_FRAME_ASSEMBLER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define BSFA_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BSFA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define BSFA_ASSERT_IMPL(lbl, ante, cons, msg)

`define BSFA_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

### hw/rtl/bsfa_pkg.sv
// ----------------------------------------------------------------------------
// bsfa_pkg
// sizes, codes and controller/datapath handshake types of the frame assembler
// ----------------------------------------------------------------------------
`default_nettype none

package bsfa_pkg;

   // frame store geometry
   localparam int MaxFrame = 64;
   localparam int AddrW    = $clog2(MaxFrame);
   localparam int CountW   = AddrW + 1;
   localparam logic [CountW-1:0] MaxCount = CountW'(MaxFrame);

   // delimiter
   localparam int DelimMax = 4;
   localparam int DlenW    = 3;
   localparam int DelimW   = 32;

   // input commands
   localparam logic [1:0] CMD_DATA  = 2'd0;
   localparam logic [1:0] CMD_FLUSH = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;
   localparam logic [1:0] CMD_NONE  = 2'd3;

   // result kinds
   localparam logic [1:0] KIND_BYTE  = 2'd0;
   localparam logic [1:0] KIND_MARK  = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   // error codes
   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_TOO_LONG  = 3'd1;
   localparam logic [2:0] ERR_OVERFLOW  = 3'd2;
   localparam logic [2:0] ERR_BAD_MAX   = 3'd3;
   localparam logic [2:0] ERR_BAD_FIXED = 3'd4;
   localparam logic [2:0] ERR_FIX_MAX   = 3'd5;
   localparam logic [2:0] ERR_NO_DELIM  = 3'd6;

   // register indexes
   localparam int RegIdxW = 3;
   localparam logic [RegIdxW-1:0] REG_MODE  = 3'd0;
   localparam logic [RegIdxW-1:0] REG_FIXED = 3'd1;
   localparam logic [RegIdxW-1:0] REG_MAX   = 3'd2;
   localparam logic [RegIdxW-1:0] REG_DELIM = 3'd3;
   localparam logic [RegIdxW-1:0] REG_DLEN  = 3'd4;
   localparam logic [RegIdxW-1:0] REG_INCL  = 3'd5;

   // outcome of evaluating one item
   localparam logic [1:0] ACT_NONE   = 2'd0;
   localparam logic [1:0] ACT_SINGLE = 2'd1;
   localparam logic [1:0] ACT_FRAME  = 2'd2;

   typedef struct packed {
      logic in_ready;
      logic eval;
      logic load_single;
      logic put_byte;
   } ctrl_cmd_type;

   typedef struct packed {
      logic       in_valid;
      logic [1:0] action;
      logic       slot_free;
      logic       last_byte;
   } dp_status_type;

endpackage

`default_nettype wire

### hw/rtl/bsfa_if.sv
// ----------------------------------------------------------------------------
// bsfa channel interfaces
// valid/ready channels for input items, result items and register writes
// ----------------------------------------------------------------------------
`default_nettype none

interface bsfa_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] command;
   logic [7:0] data_byte;

   modport source (output valid, output command, output data_byte, input ready);
   modport sink   (input valid, input command, input data_byte, output ready);
endinterface

interface bsfa_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] result_kind;
   logic [7:0] frame_byte;
   logic       frame_end;
   logic [2:0] error_code;
   logic       last_result;

   modport source (output valid, output result_kind, output frame_byte,
                   output frame_end, output error_code, output last_result,
                   input ready);
   modport sink   (input valid, input result_kind, input frame_byte,
                   input frame_end, input error_code, input last_result,
                   output ready);
endinterface

interface bsfa_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  reg_index;
   logic [31:0] wr_data;

   modport source (output valid, output reg_index, output wr_data, input ready);
   modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

`default_nettype wire

### hw/rtl/bsfa_ctrl.sv
// ----------------------------------------------------------------------------
// bsfa_ctrl
// sequencer: accept, evaluate, then return to idle, deliver one result or walk a frame
// ----------------------------------------------------------------------------
`default_nettype none
`include "byte_stream_frame_assembler_top_macros.svh"

module bsfa_ctrl
   import bsfa_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_EVAL = 3'd1;
   localparam logic [2:0] S_ONE  = 3'd2;
   localparam logic [2:0] S_RD   = 3'd3;
   localparam logic [2:0] S_PUT  = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            cmd.in_ready = 1'b1;
            if (status.in_valid) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
            if (status.action == ACT_SINGLE) begin
               state_in = S_ONE;
            end else if (status.action == ACT_FRAME) begin
               state_in = S_RD;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_ONE: begin
            if (status.slot_free) begin
               cmd.load_single = 1'b1;
               state_in        = S_IDLE;
            end
         end
         // store read data is registered and lands in the next cycle
         S_RD: begin
            state_in = S_PUT;
         end
         S_PUT: begin
            if (status.slot_free) begin
               cmd.put_byte = 1'b1;
               state_in     = status.last_byte ? S_IDLE : S_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `BSFA_ASSERT_NEXT(a_accept_eval, status.in_valid && cmd.in_ready, state_ff == S_EVAL, "accepted item not evaluated")
   `BSFA_ASSERT_IMPL(a_one_origin, state_ff == S_ONE, $past(state_ff) == S_EVAL || $past(state_ff) == S_ONE, "single result without evaluation")
   `BSFA_ASSERT_IMPL(a_put_origin, state_ff == S_PUT, $past(state_ff) == S_RD || $past(state_ff) == S_PUT, "frame byte put without store read")

endmodule

`default_nettype wire

### hw/rtl/bsfa_dp.sv
// ----------------------------------------------------------------------------
// bsfa_dp
// registers, frame store, item evaluation and the result register
// ----------------------------------------------------------------------------
`default_nettype none
`include "byte_stream_frame_assembler_top_macros.svh"

module bsfa_dp
   import bsfa_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   bsfa_req_if.sink      req,
   bsfa_rsp_if.source    rsp,
   bsfa_csr_if.sink      csr,
   input  ctrl_cmd_type  cmd,
   output dp_status_type status
);

   function automatic logic [DelimW-1:0] delim_mask(input logic [DlenW-1:0] d);
      logic [DelimW-1:0] m;
      case (d)
         3'd1:    m = 32'h0000_00FF;
         3'd2:    m = 32'h0000_FFFF;
         3'd3:    m = 32'h00FF_FFFF;
         default: m = 32'hFFFF_FFFF;
      endcase
      return m;
   endfunction

   // configuration
   logic              mode_ff;
   logic [CountW-1:0] fixed_ff;
   logic [CountW-1:0] max_ff;
   logic [DelimW-1:0] delim_ff;
   logic [DlenW-1:0]  dlen_ff;
   logic              incl_ff;

   // buffer state
   logic [CountW-1:0] count_ff;
   logic [CountW-1:0] count_in;
   logic [DelimW-1:0] recent_ff;
   logic [DelimW-1:0] recent_in;
   logic [7:0]        store_mem [MaxFrame];
   logic [7:0]        rd_data_ff;

   // latched item
   logic [1:0] in_cmd_ff;
   logic [7:0] in_byte_ff;

   // pending single result and frame walk
   logic [1:0]        sgl_kind_ff;
   logic [1:0]        sgl_kind_in;
   logic [2:0]        sgl_code_ff;
   logic [2:0]        sgl_code_in;
   logic [CountW-1:0] len_ff;
   logic [CountW-1:0] len_in;
   logic [AddrW-1:0]  idx_ff;

   // result register
   logic       out_valid_ff;
   logic [1:0] out_kind_ff;
   logic [7:0] out_byte_ff;
   logic       out_end_ff;
   logic [2:0] out_code_ff;
   logic       out_last_ff;

   logic [CountW-1:0] eff_max;
   logic [DlenW-1:0]  eff_dlen;
   logic [DelimW-1:0] dmask;
   logic [2:0]        cfg_err;
   logic [CountW-1:0] cnt_new;
   logic [DelimW-1:0] rec_new;
   logic              dmatch;
   logic [CountW-1:0] dframe_len;
   logic [1:0]        action;
   logic              mem_we;
   logic              csr_wr;
   logic              slot_free;
   logic              last_byte;

   assign csr.ready = 1'b1;
   assign req.ready = cmd.in_ready;
   assign csr_wr    = csr.valid && (csr.reg_index <= REG_INCL);

   assign eff_max  = (max_ff > MaxCount) ? MaxCount : max_ff;
   assign eff_dlen = (dlen_ff > DlenW'(DelimMax)) ? DlenW'(DelimMax) : dlen_ff;
   assign dmask    = delim_mask(eff_dlen);

   always_comb begin
      if (eff_max == '0) begin
         cfg_err = ERR_BAD_MAX;
      end else if (!mode_ff) begin
         if (fixed_ff == '0) begin
            cfg_err = ERR_BAD_FIXED;
         end else if (fixed_ff > eff_max) begin
            cfg_err = ERR_FIX_MAX;
         end else begin
            cfg_err = ERR_NONE;
         end
      end else if (eff_dlen == '0) begin
         cfg_err = ERR_NO_DELIM;
      end else begin
         cfg_err = ERR_NONE;
      end
   end

   assign cnt_new    = count_ff + CountW'(1);
   assign rec_new    = {recent_ff[DelimW-9:0], in_byte_ff};
   assign dmatch     = (cnt_new >= CountW'(eff_dlen)) && ((rec_new & dmask) == (delim_ff & dmask));
   assign dframe_len = incl_ff ? cnt_new : (cnt_new - CountW'(eff_dlen));

   // evaluation of the latched item
   always_comb begin
      action      = ACT_NONE;
      sgl_kind_in = KIND_ERROR;
      sgl_code_in = ERR_NONE;
      len_in      = len_ff;
      count_in    = count_ff;
      recent_in   = recent_ff;
      mem_we      = 1'b0;
      case (in_cmd_ff) inside
         CMD_CLEAR: begin
            count_in  = '0;
            recent_in = '0;
         end
         CMD_DATA, CMD_FLUSH: begin
            if (cfg_err != ERR_NONE) begin
               count_in    = '0;
               recent_in   = '0;
               action      = ACT_SINGLE;
               sgl_code_in = cfg_err;
            end else if (in_cmd_ff == CMD_FLUSH) begin
               if (count_ff != '0) begin
                  action    = ACT_FRAME;
                  len_in    = count_ff;
                  count_in  = '0;
                  recent_in = '0;
               end
            end else begin
               mem_we    = (count_ff < MaxCount);
               count_in  = cnt_new;
               recent_in = rec_new;
               if (!mode_ff) begin
                  if (cnt_new >= fixed_ff) begin
                     action    = ACT_FRAME;
                     len_in    = fixed_ff;
                     count_in  = '0;
                     recent_in = '0;
                  end
               end else if (dmatch) begin
                  count_in  = '0;
                  recent_in = '0;
                  action    = ACT_SINGLE;
                  if (cnt_new > eff_max) begin
                     sgl_code_in = ERR_TOO_LONG;
                  end else if (dframe_len == '0) begin
                     sgl_kind_in = KIND_MARK;
                  end else begin
                     action = ACT_FRAME;
                     len_in = dframe_len;
                  end
               end else if (cnt_new > eff_max) begin
                  count_in    = '0;
                  recent_in   = '0;
                  action      = ACT_SINGLE;
                  sgl_code_in = ERR_OVERFLOW;
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign slot_free = !out_valid_ff || rsp.ready;
   assign last_byte = ({1'b0, idx_ff} == (len_ff - CountW'(1)));

   assign status.in_valid  = req.valid;
   assign status.action    = action;
   assign status.slot_free = slot_free;
   assign status.last_byte = last_byte;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= 1'b0;
         fixed_ff <= CountW'(1);
         max_ff   <= CountW'(64);
         delim_ff <= DelimW'(10);
         dlen_ff  <= DlenW'(1);
         incl_ff  <= 1'b0;
      end else if (csr.valid) begin
         unique case (csr.reg_index)
            REG_MODE:  mode_ff  <= csr.wr_data[0];
            REG_FIXED: fixed_ff <= csr.wr_data[CountW-1:0];
            REG_MAX:   max_ff   <= csr.wr_data[CountW-1:0];
            REG_DELIM: delim_ff <= csr.wr_data;
            REG_DLEN:  dlen_ff  <= csr.wr_data[DlenW-1:0];
            REG_INCL:  incl_ff  <= csr.wr_data[0];
            default: begin
            end
         endcase
      end
   end

   // buffer count and recent bytes, a write to any defined register empties the buffer
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         recent_ff <= '0;
      end else if (csr_wr) begin
         count_ff  <= '0;
         recent_ff <= '0;
      end else if (cmd.eval) begin
         count_ff  <= count_in;
         recent_ff <= recent_in;
      end
   end

   // item latch and pending result
   always_ff @(posedge clock) begin
      if (cmd.in_ready && req.valid) begin
         in_cmd_ff  <= req.command;
         in_byte_ff <= req.data_byte;
      end
      if (cmd.eval) begin
         sgl_kind_ff <= sgl_kind_in;
         sgl_code_ff <= sgl_code_in;
         len_ff      <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else if (cmd.eval) begin
         idx_ff <= '0;
      end else if (cmd.put_byte) begin
         idx_ff <= idx_ff + AddrW'(1);
      end
   end

   // frame store
   always_ff @(posedge clock) begin
      if (cmd.eval && mem_we) begin
         store_mem[count_ff[AddrW-1:0]] <= in_byte_ff;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= store_mem[idx_ff];
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load_single || cmd.put_byte) begin
         out_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_single) begin
         out_kind_ff <= sgl_kind_ff;
         out_byte_ff <= 8'd0;
         out_end_ff  <= (sgl_kind_ff == KIND_MARK);
         out_code_ff <= sgl_code_ff;
         out_last_ff <= 1'b1;
      end else if (cmd.put_byte) begin
         out_kind_ff <= KIND_BYTE;
         out_byte_ff <= rd_data_ff;
         out_end_ff  <= last_byte;
         out_code_ff <= ERR_NONE;
         out_last_ff <= last_byte;
      end
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.result_kind = out_kind_ff;
   assign rsp.frame_byte  = out_byte_ff;
   assign rsp.frame_end   = out_end_ff;
   assign rsp.error_code  = out_code_ff;
   assign rsp.last_result = out_last_ff;

   `BSFA_ASSERT_IMPL(a_count_bound, 1'b1, count_ff <= MaxCount, "byte count beyond frame store")
   `BSFA_ASSERT_NEXT(a_csr_empties, csr_wr, count_ff == '0, "register write left bytes buffered")
   `BSFA_ASSERT_IMPL(a_error_form, out_valid_ff && out_kind_ff == KIND_ERROR, out_code_ff != ERR_NONE && !out_end_ff, "malformed error result")

endmodule

`default_nettype wire

### hw/rtl/byte_stream_frame_assembler_top.sv
// ----------------------------------------------------------------------------
// byte_stream_frame_assembler_top
// deframer for a byte stream, fixed-length or delimiter framing
// ----------------------------------------------------------------------------
//
// channel    dir  handshake     payload
// req_chan   in   valid/ready   command, data_byte
// rsp_chan   out  valid/ready   result_kind, frame_byte, frame_end, error_code,
//                               last_result
// csr_chan   in   valid/ready   reg_index, wr_data (ready tied high)
//
// an item is first accepted, then evaluated; an item that causes no result
// sends the sequencer back to accepting
// an error or empty-frame marker then loads the result register
// each byte of a frame is one registered store read followed by one load of
// the result register
// reset is synchronous and restores the register defaults with an empty
// buffer; the store itself is not cleared, no clearing pass
// a stalled rsp_chan holds the sequencer; a finished result can wait in the
// result register while the next item is accepted
//
`default_nettype none

module byte_stream_frame_assembler_top
   import bsfa_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   bsfa_req_if.sink   req_chan,
   bsfa_rsp_if.source rsp_chan,
   bsfa_csr_if.sink   csr_chan
);

   // command and status between sequencer and datapath
   ctrl_cmd_type  ctrl_cmd;
   dp_status_type dp_status;

   // sequencer
   bsfa_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (dp_status),
      .cmd    (ctrl_cmd)
   );

   // registers, frame store and result register
   bsfa_dp u_dp (
      .clock  (clock),
      .reset  (reset),
      .req    (req_chan),
      .rsp    (rsp_chan),
      .csr    (csr_chan),
      .cmd    (ctrl_cmd),
      .status (dp_status)
   );

endmodule

`default_nettype wire
